@@ sv/colormap_lerp_lookup_defines.svh @@
// ----------------------------------------------------------------------------
// Colormap lookup assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef COLORMAP_LERP_LOOKUP_DEFINES_SVH
`define COLORMAP_LERP_LOOKUP_DEFINES_SVH
`ifndef SYNTHESIS
`define CLL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CLL_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define CLL_ASSERT(lbl, clk, rst, prop, msg)
`define CLL_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

@@ sv/cll_pkg.sv @@
// ----------------------------------------------------------------------------
// Colormap lookup package
// Shared constants, codes, types and the default ramp table.
// ----------------------------------------------------------------------------
`default_nettype none
package cll_pkg;

   localparam int TABLE_DEPTH_DEF   = 256;
   localparam int SAMPLE_BITS_DEF   = 16;
   localparam int CHANNEL_BITS_DEF  = 8;
   localparam int FRACTION_BITS_DEF = 8;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;
   localparam int COUNT_BITS     = 9;
   localparam int ENTRY_BITS     = 8;
   localparam int PORT_CH_BITS   = 8;

   localparam int MIN_RESET   = 0;
   localparam int MAX_RESET   = 1;
   localparam int COUNT_RESET = 16;
   localparam int RAMP_LEN    = 16;

   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 4;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MIN   = 2'd0,
      CSR_MAX   = 2'd1,
      CSR_COUNT = 2'd2
   } csr_index_type;

   typedef enum logic {
      REQ_MAP   = 1'b0,
      REQ_WRITE = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic [PORT_CH_BITS-1:0] red;
      logic [PORT_CH_BITS-1:0] green;
      logic [PORT_CH_BITS-1:0] blue;
      logic                    range_empty;
   } rsp_type;

   typedef logic [31:0] ramp_type [RAMP_LEN];

   function automatic ramp_type build_ramp(input int ch_bits);
      ramp_type r;
      int       full;
      full = (1 << ch_bits) - 1;
      for (int i = 0; i < RAMP_LEN; i++) begin
         r[i] = 32'((i * full + 7) / 15);
      end
      return r;
   endfunction

   function automatic int mid_bits(input int ch_bits, input int idx_bits, input int frac_bits);
      return 3 + 2 * idx_bits + frac_bits + 3 * ch_bits;
   endfunction

endpackage
`default_nettype wire

@@ sv/cll_ram.sv @@
// ----------------------------------------------------------------------------
// Colormap lookup RAM
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none
module cll_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]     rd_data_a,
   input  wire logic [ADDR_BITS-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]     rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
`default_nettype wire

@@ sv/cll_fifo.sv @@
// ----------------------------------------------------------------------------
// Colormap lookup queue
// Small register queue with occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none
`include "colormap_lerp_lookup_defines.svh"
module cll_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PTR_BITS = $clog2(DEPTH),
   localparam int CNT_BITS = $clog2(DEPTH) + 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire logic [WIDTH-1:0]    push_data,
   input  wire logic                pop,
   output logic      [WIDTH-1:0]    pop_data,
   output logic      [CNT_BITS-1:0] count,
   output logic                     empty,
   output logic                     full
);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign count    = count_ff;
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_BITS'(DEPTH));

   `CLL_ASSERT_NEVER(a_no_overflow, clock, reset, push && full, "queue push while full")
   `CLL_ASSERT_NEVER(a_no_underflow, clock, reset, pop && empty, "queue pop while empty")

endmodule
`default_nettype wire

@@ sv/cll_front.sv @@
// ----------------------------------------------------------------------------
// Colormap lookup front end
// Classifies requests, normalizes the sample and divides to a table position.
// ----------------------------------------------------------------------------
`default_nettype none
`include "colormap_lerp_lookup_defines.svh"
module cll_front import cll_pkg::*; #(
   parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF,
   localparam int IDX_BITS  = $clog2(TABLE_DEPTH),
   localparam int MID_BITS  = mid_bits(CHANNEL_BITS, IDX_BITS, FRACTION_BITS)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_push,
   input  wire logic                    req_type,
   input  wire logic [SAMPLE_BITS-1:0]  sample_value,
   input  wire logic [ENTRY_BITS-1:0]   entry_index,
   input  wire logic [PORT_CH_BITS-1:0] entry_red,
   input  wire logic [PORT_CH_BITS-1:0] entry_green,
   input  wire logic [PORT_CH_BITS-1:0] entry_blue,
   input  wire logic [SAMPLE_BITS-1:0]  min_value,
   input  wire logic [SAMPLE_BITS-1:0]  max_value,
   input  wire logic [COUNT_BITS-1:0]   color_count,
   input  wire logic                    out_ready,
   output logic                         out_push,
   output logic      [MID_BITS-1:0]     out_data,
   output logic                         ready
);

   localparam int QBITS     = IDX_BITS + FRACTION_BITS;
   localparam int PROD_BITS = SAMPLE_BITS + IDX_BITS;

   typedef struct packed {
      logic                    kind;
      logic                    empty;
      logic                    wr_ok;
      logic [IDX_BITS-1:0]     wr_addr;
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
      logic [SAMPLE_BITS-1:0]  den;
      logic [IDX_BITS-1:0]     cm1;
   } ctl_type;

   typedef struct packed {
      logic                     kind;
      logic                     empty;
      logic                     wr_ok;
      logic [IDX_BITS-1:0]      idx1;
      logic [IDX_BITS-1:0]      idx2;
      logic [FRACTION_BITS-1:0] frac;
      logic [CHANNEL_BITS-1:0]  red;
      logic [CHANNEL_BITS-1:0]  green;
      logic [CHANNEL_BITS-1:0]  blue;
   } mid_type;

   logic adv;

   ctl_type                s0_ctl_in;
   logic [SAMPLE_BITS-1:0] s0_num_in;
   logic                   s0_valid_ff;
   ctl_type                s0_ctl_ff;
   logic [SAMPLE_BITS-1:0] s0_num_ff;

   logic                   s1_valid_ff;
   ctl_type                s1_ctl_ff;
   logic [PROD_BITS-1:0]   s1_prod_ff;
   logic [PROD_BITS-1:0]   s1_prod_in;

   logic                   dv_valid_ff [QBITS];
   ctl_type                dv_ctl_ff   [QBITS];
   logic [SAMPLE_BITS-1:0] dv_rem_ff   [QBITS];
   logic [QBITS-1:0]       dv_low_ff   [QBITS];
   logic [QBITS-1:0]       dv_quo_ff   [QBITS];

   logic                   dv_valid_in [QBITS];
   ctl_type                dv_ctl_in   [QBITS];
   logic [SAMPLE_BITS-1:0] dv_rem_in   [QBITS];
   logic [QBITS-1:0]       dv_low_in   [QBITS];
   logic [QBITS-1:0]       dv_quo_in   [QBITS];

   logic    tail_valid;
   ctl_type tail_ctl;
   mid_type mid;

   assign tail_valid = dv_valid_ff[QBITS-1];
   assign tail_ctl   = dv_ctl_ff[QBITS-1];
   assign adv        = !tail_valid || out_ready;
   assign ready      = adv;

   // normalize sample against range
   always_comb begin
      logic signed [SAMPLE_BITS:0] lo_x;
      logic signed [SAMPLE_BITS:0] hi_x;
      logic signed [SAMPLE_BITS:0] smp_x;
      logic signed [SAMPLE_BITS:0] num_x;
      logic signed [SAMPLE_BITS:0] den_x;
      logic [31:0]                 cnt_w;
      lo_x  = {min_value[SAMPLE_BITS-1], min_value};
      hi_x  = {max_value[SAMPLE_BITS-1], max_value};
      smp_x = {sample_value[SAMPLE_BITS-1], sample_value};
      num_x = smp_x - lo_x;
      den_x = hi_x - lo_x;
      if (den_x < 0) begin
         num_x = -num_x;
         den_x = -den_x;
      end
      if (num_x < 0) begin
         num_x = '0;
      end else if (num_x > den_x) begin
         num_x = den_x;
      end
      cnt_w = 32'(color_count);
      if (cnt_w == 32'd0) begin
         cnt_w = 32'd1;
      end else if (cnt_w > 32'(TABLE_DEPTH)) begin
         cnt_w = 32'(TABLE_DEPTH);
      end
      s0_num_in         = SAMPLE_BITS'(num_x);
      s0_ctl_in.kind    = req_type;
      s0_ctl_in.empty   = (req_type == REQ_MAP) && (min_value == max_value);
      s0_ctl_in.wr_ok   = 32'(entry_index) < 32'(TABLE_DEPTH);
      s0_ctl_in.wr_addr = IDX_BITS'(entry_index);
      s0_ctl_in.red     = CHANNEL_BITS'(entry_red);
      s0_ctl_in.green   = CHANNEL_BITS'(entry_green);
      s0_ctl_in.blue    = CHANNEL_BITS'(entry_blue);
      s0_ctl_in.den     = SAMPLE_BITS'(den_x);
      s0_ctl_in.cm1     = IDX_BITS'(cnt_w - 32'd1);
   end

   assign s1_prod_in = PROD_BITS'(s0_num_ff) * PROD_BITS'(s0_ctl_ff.cm1);

   // one quotient bit per stage
   always_comb begin
      logic [SAMPLE_BITS-1:0] s_rem;
      logic [QBITS-1:0]       s_low;
      logic [QBITS-1:0]       s_quo;
      logic [SAMPLE_BITS:0]   trial;
      logic                   ge;
      for (int k = 0; k < QBITS; k++) begin
         if (k == 0) begin
            dv_valid_in[k] = s1_valid_ff;
            dv_ctl_in[k]   = s1_ctl_ff;
            s_rem          = s1_prod_ff[PROD_BITS-1:IDX_BITS];
            s_low          = {s1_prod_ff[IDX_BITS-1:0], {FRACTION_BITS{1'b0}}};
            s_quo          = '0;
         end else begin
            dv_valid_in[k] = dv_valid_ff[k-1];
            dv_ctl_in[k]   = dv_ctl_ff[k-1];
            s_rem          = dv_rem_ff[k-1];
            s_low          = dv_low_ff[k-1];
            s_quo          = dv_quo_ff[k-1];
         end
         trial = {s_rem, s_low[QBITS-1]};
         ge    = trial >= {1'b0, dv_ctl_in[k].den};
         dv_rem_in[k] = ge ? SAMPLE_BITS'(trial - {1'b0, dv_ctl_in[k].den})
                           : SAMPLE_BITS'(trial);
         dv_low_in[k] = s_low << 1;
         dv_quo_in[k] = {s_quo[QBITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         for (int k = 0; k < QBITS; k++) begin
            dv_valid_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         s0_valid_ff <= in_push;
         s1_valid_ff <= s0_valid_ff;
         for (int k = 0; k < QBITS; k++) begin
            dv_valid_ff[k] <= dv_valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ctl_ff  <= s0_ctl_in;
         s0_num_ff  <= s0_num_in;
         s1_ctl_ff  <= s0_ctl_ff;
         s1_prod_ff <= s1_prod_in;
         for (int k = 0; k < QBITS; k++) begin
            dv_ctl_ff[k] <= dv_ctl_in[k];
            dv_rem_ff[k] <= dv_rem_in[k];
            dv_low_ff[k] <= dv_low_in[k];
            dv_quo_ff[k] <= dv_quo_in[k];
         end
      end
   end

   // split position into entry pair and fraction
   always_comb begin
      logic [QBITS-1:0]    pos;
      logic [IDX_BITS-1:0] idx_raw;
      logic [IDX_BITS-1:0] idx_lo;
      pos     = dv_quo_ff[QBITS-1];
      idx_raw = pos[QBITS-1:FRACTION_BITS];
      idx_lo  = (idx_raw > tail_ctl.cm1) ? tail_ctl.cm1 : idx_raw;
      mid.kind  = tail_ctl.kind;
      mid.empty = tail_ctl.empty;
      mid.wr_ok = tail_ctl.wr_ok;
      mid.idx1  = (tail_ctl.kind == REQ_WRITE) ? tail_ctl.wr_addr : idx_lo;
      mid.idx2  = (idx_lo == tail_ctl.cm1) ? tail_ctl.cm1 : idx_lo + 1'b1;
      mid.frac  = pos[FRACTION_BITS-1:0];
      mid.red   = tail_ctl.red;
      mid.green = tail_ctl.green;
      mid.blue  = tail_ctl.blue;
   end

   assign out_push = tail_valid && out_ready;
   assign out_data = mid;

   `CLL_ASSERT(a_tail_hold, clock, reset, tail_valid && !out_ready |=> tail_valid && $stable(dv_quo_ff[QBITS-1]), "front tail changed while stalled")

endmodule
`default_nettype wire

@@ sv/cll_back.sv @@
// ----------------------------------------------------------------------------
// Colormap lookup back end
// Owns the color table, applies writes and interpolates between entries.
// ----------------------------------------------------------------------------
`default_nettype none
`include "colormap_lerp_lookup_defines.svh"
module cll_back import cll_pkg::*; #(
   parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
   parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF,
   parameter int OUT_CNT_BITS  = $clog2(OUT_DEPTH) + 1,
   localparam int IDX_BITS = $clog2(TABLE_DEPTH),
   localparam int MID_BITS = mid_bits(CHANNEL_BITS, IDX_BITS, FRACTION_BITS)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    mid_empty,
   input  wire logic [MID_BITS-1:0]     mid_data,
   output logic                         mid_pop,
   input  wire logic [OUT_CNT_BITS-1:0] out_count,
   output logic                         out_push,
   output rsp_type                      out_data,
   output logic                         busy
);

   localparam int WORD_BITS = 3 * CHANNEL_BITS;
   localparam int PROD_BITS = CHANNEL_BITS + FRACTION_BITS + 1;
   localparam ramp_type RAMP = build_ramp(CHANNEL_BITS);

   typedef struct packed {
      logic                     kind;
      logic                     empty;
      logic                     wr_ok;
      logic [IDX_BITS-1:0]      idx1;
      logic [IDX_BITS-1:0]      idx2;
      logic [FRACTION_BITS-1:0] frac;
      logic [CHANNEL_BITS-1:0]  red;
      logic [CHANNEL_BITS-1:0]  green;
      logic [CHANNEL_BITS-1:0]  blue;
   } mid_type;

   function automatic logic [CHANNEL_BITS-1:0] lerp(
      input logic [CHANNEL_BITS-1:0]  c1,
      input logic [CHANNEL_BITS-1:0]  c2,
      input logic [FRACTION_BITS-1:0] f
   );
      logic [PROD_BITS-1:0] prod;
      if (c2 >= c1) begin
         prod = PROD_BITS'(f) * PROD_BITS'(c2 - c1);
         return c1 + CHANNEL_BITS'(prod >> FRACTION_BITS);
      end
      prod = PROD_BITS'(f) * PROD_BITS'(c1 - c2) + PROD_BITS'({FRACTION_BITS{1'b1}});
      return c1 - CHANNEL_BITS'(prod >> FRACTION_BITS);
   endfunction

   mid_type mid;
   assign mid = mid_type'(mid_data);

   logic                sweep_ff;
   logic [IDX_BITS-1:0] sweep_cnt_ff;

   logic                     b1_valid_ff;
   logic                     b1_kind_ff;
   logic                     b1_empty_ff;
   logic [FRACTION_BITS-1:0] b1_frac_ff;

   logic                 ram_we;
   logic [IDX_BITS-1:0]  ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata;
   logic [WORD_BITS-1:0] rd_a;
   logic [WORD_BITS-1:0] rd_b;
   logic [CHANNEL_BITS-1:0] ramp_level;

   assign mid_pop = !mid_empty && !sweep_ff
                    && (32'(out_count) + 32'(b1_valid_ff) < 32'(OUT_DEPTH));
   assign busy    = sweep_ff;

   // load default ramp after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= 1'b1;
         sweep_cnt_ff <= '0;
      end else if (sweep_ff) begin
         sweep_cnt_ff <= sweep_cnt_ff + 1'b1;
         if (32'(sweep_cnt_ff) == 32'(TABLE_DEPTH - 1)) begin
            sweep_ff <= 1'b0;
         end
      end
   end

   assign ramp_level = (32'(sweep_cnt_ff) < 32'(RAMP_LEN))
                       ? CHANNEL_BITS'(RAMP[4'(sweep_cnt_ff)]) : '0;

   always_comb begin
      if (sweep_ff) begin
         ram_we    = 1'b1;
         ram_waddr = sweep_cnt_ff;
         ram_wdata = {ramp_level, ramp_level, {CHANNEL_BITS{1'b0}}};
      end else begin
         ram_we    = mid_pop && (mid.kind == REQ_WRITE) && mid.wr_ok;
         ram_waddr = mid.idx1;
         ram_wdata = {mid.red, mid.green, mid.blue};
      end
   end

   cll_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_addr_a (mid.idx1),
      .rd_data_a (rd_a),
      .rd_addr_b (mid.idx2),
      .rd_data_b (rd_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= mid_pop;
      end
   end

   always_ff @(posedge clock) begin
      b1_kind_ff  <= mid.kind;
      b1_empty_ff <= mid.empty;
      b1_frac_ff  <= mid.frac;
   end

   always_comb begin
      logic [CHANNEL_BITS-1:0] r_v;
      logic [CHANNEL_BITS-1:0] g_v;
      logic [CHANNEL_BITS-1:0] b_v;
      logic                    zero;
      r_v  = lerp(rd_a[3*CHANNEL_BITS-1:2*CHANNEL_BITS],
                  rd_b[3*CHANNEL_BITS-1:2*CHANNEL_BITS], b1_frac_ff);
      g_v  = lerp(rd_a[2*CHANNEL_BITS-1:CHANNEL_BITS],
                  rd_b[2*CHANNEL_BITS-1:CHANNEL_BITS], b1_frac_ff);
      b_v  = lerp(rd_a[CHANNEL_BITS-1:0], rd_b[CHANNEL_BITS-1:0], b1_frac_ff);
      zero = (b1_kind_ff == REQ_WRITE) || b1_empty_ff;
      out_data.red         = zero ? '0 : PORT_CH_BITS'(r_v);
      out_data.green       = zero ? '0 : PORT_CH_BITS'(g_v);
      out_data.blue        = zero ? '0 : PORT_CH_BITS'(b_v);
      out_data.range_empty = (b1_kind_ff == REQ_MAP) && b1_empty_ff;
   end

   assign out_push = b1_valid_ff;

   `CLL_ASSERT_NEVER(a_no_pop_in_sweep, clock, reset, mid_pop && sweep_ff, "request taken during table load")
   `CLL_ASSERT(a_out_room, clock, reset, b1_valid_ff |-> 32'(out_count) < 32'(OUT_DEPTH), "result with no queue room")

endmodule
`default_nettype wire

@@ sv/colormap_lerp_lookup.sv @@
// ----------------------------------------------------------------------------
// Colormap lookup with linear interpolation
// Maps signed samples to RGB through a loadable color table.
// ----------------------------------------------------------------------------
// One request per clock in steady state while neither queue is full, map and
// table-write requests alike, in order. A request passes through the front end
// (normalize, multiply, one quotient bit per divider stage), then through the
// back end (table read on the two-port RAM, interpolation) before its result
// shows on the response queue. After reset the table is loaded with the
// default ramp, one entry a cycle, for all TABLE_DEPTH entries, during which
// req_full stays high.
// ----------------------------------------------------------------------------
`default_nettype none
module colormap_lerp_lookup import cll_pkg::*; #(
   parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_push,
   output logic                           req_full,
   input  wire logic                      req_type,
   input  wire logic [SAMPLE_BITS-1:0]    req_sample_value,
   input  wire logic [ENTRY_BITS-1:0]     req_entry_index,
   input  wire logic [PORT_CH_BITS-1:0]   req_entry_red,
   input  wire logic [PORT_CH_BITS-1:0]   req_entry_green,
   input  wire logic [PORT_CH_BITS-1:0]   req_entry_blue,
   output logic                           rsp_empty,
   input  wire logic                      rsp_pop,
   output logic      [PORT_CH_BITS-1:0]   rsp_red_out,
   output logic      [PORT_CH_BITS-1:0]   rsp_green_out,
   output logic      [PORT_CH_BITS-1:0]   rsp_blue_out,
   output logic                           rsp_range_empty,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int IDX_BITS     = $clog2(TABLE_DEPTH);
   localparam int MID_BITS     = mid_bits(CHANNEL_BITS, IDX_BITS, FRACTION_BITS);
   localparam int MID_CNT_BITS = $clog2(MID_DEPTH) + 1;
   localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH) + 1;
   localparam int RSP_BITS     = $bits(rsp_type);

   logic [SAMPLE_BITS-1:0] min_ff;
   logic [SAMPLE_BITS-1:0] max_ff;
   logic [COUNT_BITS-1:0]  count_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= SAMPLE_BITS'(MIN_RESET);
         max_ff   <= SAMPLE_BITS'(MAX_RESET);
         count_ff <= COUNT_BITS'(COUNT_RESET);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN:   min_ff   <= SAMPLE_BITS'(csr_wdata);
            CSR_MAX:   max_ff   <= SAMPLE_BITS'(csr_wdata);
            CSR_COUNT: count_ff <= COUNT_BITS'(csr_wdata);
            default: ;
         endcase
      end
   end

   logic                    fr_ready;
   logic                    fr_push;
   logic [MID_BITS-1:0]     fr_data;
   logic                    bk_busy;
   logic                    in_push;

   logic                    mid_pop;
   logic [MID_BITS-1:0]     mid_data;
   logic [MID_CNT_BITS-1:0] mid_count;
   logic                    mid_empty;
   logic                    mid_full;

   logic                    out_push;
   rsp_type                 out_data;
   logic [RSP_BITS-1:0]     out_q;
   logic [OUT_CNT_BITS-1:0] out_count;
   logic                    out_empty;
   logic                    out_full;
   logic                    out_pop;
   rsp_type                 rsp;

   assign req_full = !fr_ready || bk_busy;
   assign in_push  = req_push && !req_full;

   cll_front #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .CHANNEL_BITS  (CHANNEL_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_push      (in_push),
      .req_type     (req_type),
      .sample_value (req_sample_value),
      .entry_index  (req_entry_index),
      .entry_red    (req_entry_red),
      .entry_green  (req_entry_green),
      .entry_blue   (req_entry_blue),
      .min_value    (min_ff),
      .max_value    (max_ff),
      .color_count  (count_ff),
      .out_ready    (!mid_full),
      .out_push     (fr_push),
      .out_data     (fr_data),
      .ready        (fr_ready)
   );

   cll_fifo #(
      .WIDTH (MID_BITS),
      .DEPTH (MID_DEPTH)
   ) u_mid_q (
      .clock     (clock),
      .reset     (reset),
      .push      (fr_push),
      .push_data (fr_data),
      .pop       (mid_pop),
      .pop_data  (mid_data),
      .count     (mid_count),
      .empty     (mid_empty),
      .full      (mid_full)
   );

   cll_back #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .CHANNEL_BITS  (CHANNEL_BITS),
      .FRACTION_BITS (FRACTION_BITS),
      .OUT_CNT_BITS  (OUT_CNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty || (mid_count == '0)),
      .mid_data  (mid_data),
      .mid_pop   (mid_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_data  (out_data),
      .busy      (bk_busy)
   );

   assign out_pop = rsp_pop && !out_empty;

   cll_fifo #(
      .WIDTH (RSP_BITS),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .pop       (out_pop),
      .pop_data  (out_q),
      .count     (out_count),
      .empty     (out_empty),
      .full      (out_full)
   );

   assign rsp             = rsp_type'(out_q);
   assign rsp_empty       = out_empty || out_full && 1'b0;
   assign rsp_red_out     = rsp.red;
   assign rsp_green_out   = rsp.green;
   assign rsp_blue_out    = rsp.blue;
   assign rsp_range_empty = rsp.range_empty;

endmodule
`default_nettype wire
